@@ hdl/lpg_pkg.sv @@
// Shared types and constants for the line point generator.
`timescale 1ns / 1ps
`default_nettype none

package lpg_pkg;

    localparam int unsigned POS_WIDTH   = 10;
    localparam int unsigned COLOR_WIDTH = 16;

    // Command codes carried in the func field.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_NEXT = 1'b1;

    // Axis step directions.
    localparam logic [1:0] DIR_NONE  = 2'b00;
    localparam logic [1:0] DIR_PLUS  = 2'b01;
    localparam logic [1:0] DIR_MINUS = 2'b11;

    typedef struct packed {
        logic                   func;
        logic [POS_WIDTH-1:0]   x_start;
        logic [POS_WIDTH-1:0]   y_start;
        logic [POS_WIDTH-1:0]   x_finish;
        logic [POS_WIDTH-1:0]   y_finish;
        logic [COLOR_WIDTH-1:0] pixel_color;
    } t_in_item;

    typedef struct packed {
        logic [POS_WIDTH-1:0]   point_x;
        logic [POS_WIDTH-1:0]   point_y;
        logic [COLOR_WIDTH-1:0] point_color;
        logic                   point_valid;
        logic                   line_last;
    } t_out_item;

    // Handshake between the stepping core and the stages around it.
    typedef struct packed {
        logic take;
        logic emit;
    } t_step_ctl;

endpackage

`default_nettype wire

@@ hdl/lpg_in_reg.sv @@
// Input register stage holding one accepted item for the stepping core.
`timescale 1ns / 1ps
`default_nettype none

module lpg_in_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire lpg_pkg::t_in_item i_in_item,
    input  wire lpg_pkg::t_step_ctl i_ctl,
    output logic                   o_valid,
    output lpg_pkg::t_in_item      o_item
);

    logic              r_valid;
    logic              n_valid;
    lpg_pkg::t_in_item r_item;

    // The register is free when empty or when the core drains it this cycle.
    assign o_in_ready = !r_valid || i_ctl.take;
    assign n_valid    = (i_in_valid && o_in_ready) || (r_valid && !i_ctl.take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= i_in_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

@@ hdl/lpg_core.sv @@
// Line state registers and the Bresenham step logic.
`timescale 1ns / 1ps
`default_nettype none

module lpg_core #(
    parameter int unsigned COORD_WIDTH = 10
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire lpg_pkg::t_in_item  i_item,
    input  wire logic               i_out_free,
    output lpg_pkg::t_step_ctl      o_ctl,
    output lpg_pkg::t_out_item      o_result
);

    localparam int unsigned CW = COORD_WIDTH;
    localparam int unsigned PW = lpg_pkg::POS_WIDTH;

    logic [CW-1:0]                   r_cur_col, r_cur_row;
    logic [CW:0]                     r_err_col, r_err_row;
    logic [CW-1:0]                   r_abs_dcol, r_abs_drow;
    logic [1:0]                      r_dir_col, r_dir_row;
    logic [CW-1:0]                   r_major_dist;
    logic [CW:0]                     r_points_left;
    logic                            r_line_active;
    logic [lpg_pkg::COLOR_WIDTH-1:0] r_line_color;

    logic [CW-1:0]                   n_cur_col, n_cur_row;
    logic [CW:0]                     n_err_col, n_err_row;
    logic [CW-1:0]                   n_abs_dcol, n_abs_drow;
    logic [1:0]                      n_dir_col, n_dir_row;
    logic [CW-1:0]                   n_major_dist;
    logic [CW:0]                     n_points_left;
    logic                            n_line_active;
    logic [lpg_pkg::COLOR_WIDTH-1:0] n_line_color;

    logic          is_load;
    logic          take;
    logic [CW-1:0] xs, ys, xf, yf;
    logic [CW:0]   pl_dec;
    logic [2*CW:0] adv_col, adv_row;

    function automatic logic [CW+1:0] f_axis(input logic [CW-1:0] from,
                                             input logic [CW-1:0] to);
        logic [1:0]    dir;
        logic [CW-1:0] mag;
        if (to > from) begin
            dir = lpg_pkg::DIR_PLUS;
            mag = to - from;
        end else if (to == from) begin
            dir = lpg_pkg::DIR_NONE;
            mag = '0;
        end else begin
            dir = lpg_pkg::DIR_MINUS;
            mag = from - to;
        end
        return {dir, mag};
    endfunction

    // Adds the delta to the error sum and steps the axis once it passes the distance.
    function automatic logic [2*CW:0] f_advance(input logic [CW-1:0] pos,
                                                input logic [CW:0]   err,
                                                input logic [CW-1:0] mag,
                                                input logic [1:0]    dir,
                                                input logic [CW-1:0] major);
        logic [CW:0]   e;
        logic [CW-1:0] p;
        e = err + {1'b0, mag};
        p = pos;
        if (e > {1'b0, major}) begin
            e = e - {1'b0, major};
            case (dir)
                lpg_pkg::DIR_PLUS:  p = pos + 1'b1;
                lpg_pkg::DIR_MINUS: p = pos - 1'b1;
                default:            p = pos;
            endcase
        end
        return {p, e};
    endfunction

    assign is_load = (i_item.func == lpg_pkg::FUNC_LOAD);
    assign take    = i_valid && (is_load || i_out_free);

    assign xs = CW'(i_item.x_start);
    assign ys = CW'(i_item.y_start);
    assign xf = CW'(i_item.x_finish);
    assign yf = CW'(i_item.y_finish);

    assign pl_dec  = r_points_left - 1'b1;
    assign adv_col = f_advance(r_cur_col, r_err_col, r_abs_dcol, r_dir_col, r_major_dist);
    assign adv_row = f_advance(r_cur_row, r_err_row, r_abs_drow, r_dir_row, r_major_dist);

    always_comb begin
        n_cur_col     = r_cur_col;
        n_cur_row     = r_cur_row;
        n_err_col     = r_err_col;
        n_err_row     = r_err_row;
        n_abs_dcol    = r_abs_dcol;
        n_abs_drow    = r_abs_drow;
        n_dir_col     = r_dir_col;
        n_dir_row     = r_dir_row;
        n_major_dist  = r_major_dist;
        n_points_left = r_points_left;
        n_line_active = r_line_active;
        n_line_color  = r_line_color;
        o_result      = '0;

        if (take && is_load) begin
            {n_dir_col, n_abs_dcol} = f_axis(xs, xf);
            {n_dir_row, n_abs_drow} = f_axis(ys, yf);
            n_major_dist  = (n_abs_dcol > n_abs_drow) ? n_abs_dcol : n_abs_drow;
            n_cur_col     = xs;
            n_cur_row     = ys;
            n_err_col     = '0;
            n_err_row     = '0;
            n_points_left = {1'b0, n_major_dist} + (CW+1)'(2);
            n_line_color  = i_item.pixel_color;
            n_line_active = 1'b1;
        end else if (take) begin
            if (!r_line_active || r_points_left == '0) begin
                n_line_active = 1'b0;
            end else begin
                o_result.point_x     = PW'(r_cur_col);
                o_result.point_y     = PW'(r_cur_row);
                o_result.point_color = r_line_color;
                o_result.point_valid = 1'b1;
                o_result.line_last   = (pl_dec == '0);
                n_points_left        = pl_dec;
                if (pl_dec == '0) begin
                    n_line_active = 1'b0;
                end
                {n_cur_col, n_err_col} = adv_col;
                {n_cur_row, n_err_row} = adv_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col     <= '0;
            r_cur_row     <= '0;
            r_err_col     <= '0;
            r_err_row     <= '0;
            r_abs_dcol    <= '0;
            r_abs_drow    <= '0;
            r_dir_col     <= lpg_pkg::DIR_NONE;
            r_dir_row     <= lpg_pkg::DIR_NONE;
            r_major_dist  <= '0;
            r_points_left <= '0;
            r_line_active <= 1'b0;
            r_line_color  <= '0;
        end else begin
            r_cur_col     <= n_cur_col;
            r_cur_row     <= n_cur_row;
            r_err_col     <= n_err_col;
            r_err_row     <= n_err_row;
            r_abs_dcol    <= n_abs_dcol;
            r_abs_drow    <= n_abs_drow;
            r_dir_col     <= n_dir_col;
            r_dir_row     <= n_dir_row;
            r_major_dist  <= n_major_dist;
            r_points_left <= n_points_left;
            r_line_active <= n_line_active;
            r_line_color  <= n_line_color;
        end
    end

    assign o_ctl.take = take;
    assign o_ctl.emit = take && !is_load;

    // A line is active exactly while points remain to be emitted.
    a_active_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_active == (r_points_left != '0))
        else $error("line active flag disagrees with remaining point count");

    a_err_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err_col <= {1'b0, r_major_dist}) && (r_err_row <= {1'b0, r_major_dist}))
        else $error("error sum exceeds the major distance");

    a_dir_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_abs_dcol == '0) == (r_dir_col == lpg_pkg::DIR_NONE))
        && ((r_abs_drow == '0) == (r_dir_row == lpg_pkg::DIR_NONE)))
        else $error("axis direction disagrees with its delta");

    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && is_load |=> r_err_col == '0 && r_err_row == '0 && r_line_active)
        else $error("load item did not restart the line");

endmodule

`default_nettype wire

@@ hdl/lpg_out_reg.sv @@
// Result register that holds one item until the consumer takes it.
`timescale 1ns / 1ps
`default_nettype none

module lpg_out_reg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lpg_pkg::t_step_ctl i_ctl,
    input  wire lpg_pkg::t_out_item i_result,
    output logic                    o_free,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output lpg_pkg::t_out_item      o_out_item
);

    logic               r_valid;
    logic               n_valid;
    lpg_pkg::t_out_item r_item;

    assign o_free  = !r_valid || i_out_ready;
    assign n_valid = i_ctl.emit || (r_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_item <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule

`default_nettype wire

@@ hdl/line_point_generator.sv @@
// Top level of the line point generator: input register, stepping core, result register.
//
//  Channel  Direction  Handshake                 Payload
//  in       input      i_in_valid / o_in_ready   i_in_item  (lpg_pkg::t_in_item)
//  out      output     o_out_valid / i_out_ready o_out_item (lpg_pkg::t_out_item)
//
// One item is accepted per cycle while the input register is free; a next item goes from
// the input register through the core's step into the result register.
// A load item gives no result.
// The step itself is made of two add-and-compare pairs in the core.
// Reset is synchronous and clears the line state; no line is active afterward.
// A stalled result only holds the input register when it carries a next item.
`timescale 1ns / 1ps
`default_nettype none

module line_point_generator #(
    parameter int unsigned COORD_WIDTH = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire lpg_pkg::t_in_item i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output lpg_pkg::t_out_item     o_out_item
);

    logic               item_valid;
    lpg_pkg::t_in_item  item;
    lpg_pkg::t_step_ctl ctl;
    lpg_pkg::t_out_item result;
    logic               out_free;

    lpg_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_ctl      (ctl),
        .o_valid    (item_valid),
        .o_item     (item)
    );

    lpg_core #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (item_valid),
        .i_item     (item),
        .i_out_free (out_free),
        .o_ctl      (ctl),
        .o_result   (result)
    );

    lpg_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_result    (result),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
